// ----- sv/mwcm_pkg.sv -----
// Shared constants, codes and controller/datapath link types for the coverage map.
package mwcm_pkg;

  localparam int STORE_WORDS_DEF = 128;
  localparam int MAX_RESULTS     = 64;
  localparam int RUN_CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int ADDR_W    = 16;
  localparam int WORDS_W   = 8;
  localparam int GAP_LEN_W = 8;
  localparam int STATUS_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WORDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_REWRITE = 2'd2;

  localparam logic [WORDS_W-1:0] WINDOW_WORDS_RST = 8'd128;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REWRITE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                clr_step;
    logic                capture;
    logic                init;
    logic                walk;
    logic                flush;
    logic                resp;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic is_report;
    logic range_bad;
    logic rewrite_hit;
    logic run_limit;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/mwcm_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface mwcm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] addr;
  logic [15:0] length;

  modport source (output valid, output kind, output addr, output length, input ready);
  modport sink   (input valid, input kind, input addr, input length, output ready);
endinterface

interface mwcm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        gap_found;
  logic [15:0] gap_start;
  logic [7:0]  gap_length;
  logic        last;

  modport source (output valid, output status, output gap_found, output gap_start,
                  output gap_length, output last, input ready);
  modport sink   (input valid, input status, input gap_found, input gap_start,
                  input gap_length, input last, output ready);
endinterface

// ----- sv/mwcm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mwcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/mwcm_ctrl.sv -----
// Controller state machine: clearing pass, item intake, walk sequencing and result push.
module mwcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mwcm_pkg::sts_t  sts,
  output mwcm_pkg::cmd_t  cmd
);
  import mwcm_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.init = 1'b1;
        if (!sts.is_report && sts.range_bad) begin
          status_nxt = STATUS_RANGE;
          state_nxt  = ST_RESP;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        priority if (sts.rewrite_hit) begin
          status_nxt = STATUS_REWRITE;
          state_nxt  = ST_RESP;
        end else if (sts.run_limit) begin
          state_nxt = ST_FLUSH;
        end else if (sts.walk_done) begin
          if (sts.is_report) begin
            state_nxt = ST_FLUSH;
          end else begin
            status_nxt = STATUS_OK;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        cmd.resp   = 1'b1;
        cmd.status = status_r;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      status_r <= STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ----- sv/mwcm_dp.sv -----
// Datapath: config registers, flag RAM, walk pipeline, run tracking and output register.
module mwcm_dp #(
  parameter int STORE_WORDS = mwcm_pkg::STORE_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mwcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_kind,
  input  logic [mwcm_pkg::ADDR_W-1:0]      in_addr,
  input  logic [mwcm_pkg::ADDR_W-1:0]      in_length,
  input  mwcm_pkg::cmd_t                   cmd,
  output mwcm_pkg::sts_t                   sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mwcm_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_gap_found,
  output logic [mwcm_pkg::ADDR_W-1:0]      out_gap_start,
  output logic [mwcm_pkg::GAP_LEN_W-1:0]   out_gap_length,
  output logic                             out_last
);
  import mwcm_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int IW = $clog2(STORE_WORDS + 2);

  // Configuration
  logic [ADDR_W-1:0]  ws_r;
  logic [WORDS_W-1:0] ww_r;
  logic               rej_r;

  // Captured item
  logic               kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  len_r;

  // Walk pipeline
  logic [IW-1:0]      iss_r;
  logic [IW-1:0]      end_r;
  logic               ev_vld_r;
  logic [IW-1:0]      ev_idx_r;

  // Run tracking
  logic               in_run_r;
  logic [IW-1:0]      run_start_r;
  logic [IW-1:0]      run_len_r;
  logic               pend_vld_r;
  logic [IW-1:0]      pend_start_r;
  logic [IW-1:0]      pend_len_r;
  logic [RUN_CNT_W-1:0] run_cnt_r;

  // Output register
  logic                 out_vld_r;
  logic [STATUS_W-1:0]  o_status_r;
  logic                 o_found_r;
  logic [ADDR_W-1:0]    o_start_r;
  logic [GAP_LEN_W-1:0] o_len_r;
  logic                 o_last_r;

  logic [IW-1:0]      size_w;
  logic [ADDR_W:0]    hi_addr;
  logic [ADDR_W:0]    hi_win;
  logic               range_bad;
  logic [ADDR_W-1:0]  off;
  logic [ADDR_W-1:0]  wr_end;
  logic               rd_flag;
  logic               ev_free;
  logic               ev_rpt;
  logic               ev_wr;
  logic               close;
  logic               out_free;
  logic               stall;
  logic               adv;
  logic               rewrite_hit;
  logic               mark;
  logic               issue;
  logic               push_mid;
  logic               push_fin;
  logic               push_rsp;
  logic [ADDR_W-1:0]    pend_addr;
  logic [GAP_LEN_W-1:0] pend_len_sat;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  always_comb begin
    size_w = (32'(ww_r) < STORE_WORDS) ? IW'(ww_r) : IW'(STORE_WORDS);

    // Range check without wrap
    hi_addr   = {1'b0, addr_r} + {1'b0, len_r};
    hi_win    = {1'b0, ws_r} + (ADDR_W + 1)'(size_w);
    range_bad = (addr_r < ws_r) || (hi_addr > hi_win);
    off       = addr_r - ws_r;
    wr_end    = off + len_r;

    ev_free     = (ev_idx_r < size_w) && !rd_flag;
    ev_rpt      = cmd.walk && ev_vld_r && (kind_r == KIND_REPORT);
    ev_wr       = cmd.walk && ev_vld_r && (kind_r == KIND_WRITE);
    close       = ev_rpt && !ev_free && in_run_r;
    out_free    = !out_vld_r || out_ready;
    stall       = close && pend_vld_r && !out_free;
    adv         = cmd.walk && !stall;
    rewrite_hit = ev_wr && rd_flag && rej_r;
    mark        = ev_wr && !(rd_flag && rej_r);
    issue       = adv && (iss_r != end_r);

    push_mid = adv && close && pend_vld_r;
    push_fin = cmd.flush && out_free;
    push_rsp = cmd.resp && out_free;

    pend_addr    = ws_r + 16'(pend_start_r);
    pend_len_sat = (32'(pend_len_r) > 255) ? 8'd255 : 8'(pend_len_r);

    ram_we    = cmd.clr_step || mark;
    ram_waddr = cmd.clr_step ? iss_r[AW-1:0] : ev_idx_r[AW-1:0];

    sts.clr_done    = cmd.clr_step && (iss_r == IW'(STORE_WORDS - 1));
    sts.is_report   = (kind_r == KIND_REPORT);
    sts.range_bad   = range_bad;
    sts.rewrite_hit = rewrite_hit;
    sts.run_limit   = adv && close && (run_cnt_r == RUN_CNT_W'(MAX_RESULTS - 1));
    sts.walk_done   = !ev_vld_r && (iss_r == end_r);
    sts.out_free    = out_free;
  end

  mwcm_ram #(
    .WIDTH (1),
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (!cmd.clr_step),
    .re    (adv),
    .raddr (iss_r[AW-1:0]),
    .rdata (rd_flag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r  <= '0;
      ww_r  <= WINDOW_WORDS_RST;
      rej_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_START:   ws_r  <= cfg_data;
        CFG_WINDOW_WORDS:   ww_r  <= cfg_data[WORDS_W-1:0];
        CFG_REJECT_REWRITE: rej_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      addr_r <= in_addr;
      len_r  <= in_length;
    end
  end

  // Walk pipeline: issue a read, evaluate it in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r    <= '0;
      end_r    <= '0;
      ev_vld_r <= 1'b0;
      ev_idx_r <= '0;
    end else if (cmd.clr_step) begin
      iss_r <= iss_r + 1'b1;
    end else if (cmd.init) begin
      ev_vld_r <= 1'b0;
      if (kind_r == KIND_REPORT) begin
        iss_r <= '0;
        end_r <= size_w + 1'b1;
      end else begin
        iss_r <= IW'(off);
        end_r <= IW'(wr_end);
      end
    end else if (adv) begin
      ev_vld_r <= issue;
      if (issue) begin
        ev_idx_r <= iss_r;
        iss_r    <= iss_r + 1'b1;
      end
    end
  end

  // Track the open run and one finished run held back until its successor is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r     <= 1'b0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      pend_vld_r   <= 1'b0;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      run_cnt_r    <= '0;
    end else if (cmd.init) begin
      in_run_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      run_cnt_r  <= '0;
    end else if (adv && ev_rpt) begin
      if (ev_free) begin
        if (!in_run_r) begin
          in_run_r    <= 1'b1;
          run_start_r <= ev_idx_r;
          run_len_r   <= IW'(1);
        end else begin
          run_len_r <= run_len_r + 1'b1;
        end
      end else if (in_run_r) begin
        in_run_r     <= 1'b0;
        pend_vld_r   <= 1'b1;
        pend_start_r <= run_start_r;
        pend_len_r   <= run_len_r;
        run_cnt_r    <= run_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push_mid || push_fin || push_rsp) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid) begin
      o_status_r <= STATUS_OK;
      o_found_r  <= 1'b1;
      o_start_r  <= pend_addr;
      o_len_r    <= pend_len_sat;
      o_last_r   <= 1'b0;
    end else if (push_fin) begin
      o_status_r <= STATUS_OK;
      o_found_r  <= pend_vld_r;
      o_start_r  <= pend_vld_r ? pend_addr : '0;
      o_len_r    <= pend_vld_r ? pend_len_sat : '0;
      o_last_r   <= 1'b1;
    end else if (push_rsp) begin
      o_status_r <= cmd.status;
      o_found_r  <= 1'b0;
      o_start_r  <= '0;
      o_len_r    <= '0;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status     = o_status_r;
  assign out_gap_found  = o_found_r;
  assign out_gap_start  = o_start_r;
  assign out_gap_length = o_len_r;
  assign out_last       = o_last_r;

`ifndef ASSERT_OFF
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({push_mid, push_fin, push_rsp}))
    else $error("more than one result pushed in a cycle");

  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= RUN_CNT_W'(MAX_RESULTS))
    else $error("run count beyond result limit");

  a_wr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ev_wr |-> (ev_idx_r < end_r))
    else $error("write walk evaluates past end of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stall && !cmd.init) |=> $stable(ev_idx_r) && $stable(pend_start_r))
    else $error("walk pipeline moved during a stall");
`endif

endmodule

// ----- sv/memory_write_coverage_map.sv -----
// Top level of the memory write coverage map: controller and datapath joined by cmd/sts.
// Write item: the result follows a walk over its words (out-of-range: no walk, rewrite stop: walk ends early).
// Report item: walks size words, one word per cycle while the result channel does not stall it,
// size = min(window_words, STORE_WORDS). One item is worked on at a time.
// The flag RAM's single read port and single write port set the one-word-per-cycle walk.
// Reset (rst_n low, synchronous) restores the config registers, then a clearing pass
// zeroes the flags with in_if.ready low; config writes are taken throughout.
module memory_write_coverage_map #(
  parameter int STORE_WORDS = mwcm_pkg::STORE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mwcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwcm_pkg::CFG_DATA_W-1:0] cfg_data,
  mwcm_in_if.sink                         in_if,
  mwcm_out_if.source                      out_if
);
  import mwcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: owns sequencing and the input handshake
  mwcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: flag store, walk pipeline, run tracking and the result register
  mwcm_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_if.kind),
    .in_addr        (in_if.addr),
    .in_length      (in_if.length),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_status     (out_if.status),
    .out_gap_found  (out_if.gap_found),
    .out_gap_start  (out_if.gap_start),
    .out_gap_length (out_if.gap_length),
    .out_last       (out_if.last)
  );

endmodule

// ----- tb/sv/memory_write_coverage_map_test.sv -----
// Self-checking testbench for the memory write coverage map: directed edges plus random traffic.
`timescale 1ns / 100ps

module memory_write_coverage_map_test;
  import mwcm_pkg::*;

  localparam int MAP_WORDS      = STORE_WORDS_DEF;
  // Cycles to let pass once the last result is in, before touching a register
  localparam int SETTLE_CYCLES  = 8;
  // Idle limit for the watchdog, well above a full report scan plus stalls
  localparam int WATCHDOG_LIMIT = 1500;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 gap_found;
    logic [ADDR_W-1:0]    gap_start;
    logic [GAP_LEN_W-1:0] gap_length;
    logic                 last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mwcm_in_if  in_ch ();
  mwcm_out_if out_ch ();

  memory_write_coverage_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block: register settings and one written flag per store word
  logic [ADDR_W-1:0]  win_start     = '0;
  logic [WORDS_W-1:0] win_words     = WINDOW_WORDS_RST;
  logic               rewrite_check = 1'b0;
  bit [MAP_WORDS-1:0] word_written  = '0;

  // Results still owed by the block, oldest first
  result_t awaited_results[$];

  // When set, neither side inserts idle cycles
  bit calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_reports = 0;
  int unsigned n_results = 0;
  int unsigned n_range = 0;
  int unsigned n_rewrite = 0;
  int unsigned most_gaps = 0;

  function automatic int unsigned tracked_words();
    return (win_words < MAP_WORDS) ? win_words : MAP_WORDS;
  endfunction

  // Work out the results of one accepted item and queue them up.
  task automatic map_item(input logic kind, input logic [ADDR_W-1:0] addr,
                          input logic [15:0] len);
    int unsigned size, off, k, runs, run_start, run_len;
    bit in_run, stopped, held;
    result_t pend;
    size = tracked_words();
    pend = '0;
    in_run = 1'b0;
    stopped = 1'b0;
    held = 1'b0;
    runs = 0;
    run_start = 0;
    run_len = 0;
    if (kind == KIND_WRITE) begin
      pend.status = STATUS_OK;
      // Range check is done wide so nothing wraps at the top of the address space
      if (32'(addr) < 32'(win_start) || 32'(addr) + 32'(len) > 32'(win_start) + size) begin
        pend.status = STATUS_RANGE;
        n_range++;
      end else begin
        off = 32'(addr) - 32'(win_start);
        for (k = off; k < off + len && !stopped; k++) begin
          if (word_written[k]) begin
            // Words marked before the hit stay marked
            if (rewrite_check) begin
              pend.status = STATUS_REWRITE;
              stopped = 1'b1;
              n_rewrite++;
            end
          end else begin
            word_written[k] = 1'b1;
          end
        end
      end
    end else begin
      n_reports++;
      // Hold each run back one step so the final one can carry last
      for (k = 0; k <= size && runs < MAX_RESULTS; k++) begin
        if (k < size && !word_written[k]) begin
          if (!in_run) begin
            in_run = 1'b1;
            run_start = k;
            run_len = 0;
          end
          run_len++;
        end else if (in_run) begin
          if (held) awaited_results.push_back(pend);
          pend = '0;
          pend.gap_found = 1'b1;
          pend.gap_start = win_start + 16'(run_start);
          pend.gap_length = (run_len > 255) ? 8'hFF : 8'(run_len);
          held = 1'b1;
          in_run = 1'b0;
          runs++;
        end
      end
      if (runs > most_gaps) most_gaps = runs;
    end
    pend.last = 1'b1;
    awaited_results.push_back(pend);
  endtask

  task automatic check_result(input result_t seen);
    result_t want;
    n_results++;
    if (awaited_results.size() == 0) begin
      $error("result with nothing expected: status %0d gap_found %0d gap_start %0h",
             seen.status, seen.gap_found, seen.gap_start);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      if (seen.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, seen.status);
        mismatches++;
      end
      if (seen.gap_found !== want.gap_found) begin
        $error("gap_found expected %0d actual %0d", want.gap_found, seen.gap_found);
        mismatches++;
      end
      if (seen.gap_start !== want.gap_start) begin
        $error("gap_start expected %0h actual %0h", want.gap_start, seen.gap_start);
        mismatches++;
      end
      if (seen.gap_length !== want.gap_length) begin
        $error("gap_length expected %0d actual %0d", want.gap_length, seen.gap_length);
        mismatches++;
      end
      if (seen.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, seen.last);
        mismatches++;
      end
    end
  endtask

  // Sample every handshake at the rising edge: register writes update the shadow,
  // accepted items feed the predictor, accepted results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (cfg_we) begin
        idle_cycles = 0;
        case (cfg_index)
          CFG_WINDOW_START:   win_start = cfg_data[ADDR_W-1:0];
          CFG_WINDOW_WORDS:   win_words = cfg_data[WORDS_W-1:0];
          CFG_REJECT_REWRITE: rewrite_check = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
        n_items++;
        map_item(in_ch.kind, in_ch.addr, in_ch.length);
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        check_result({out_ch.status, out_ch.gap_found, out_ch.gap_start,
                      out_ch.gap_length, out_ch.last});
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stalls unless calm.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  // Offer one item, maybe after an idle burst, and hold it until accepted.
  task automatic push_item(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [15:0] len);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.kind   = kind;
    in_ch.addr   = addr;
    in_ch.length = len;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Right after reset: the whole default window is one gap of 128 words.
  task automatic test_fresh_window();
    push_item(KIND_REPORT, 16'h0000, 16'h0000);
  endtask

  // Zero lengths at both ends, one past the end, a full-scale range.
  task automatic test_range_edges();
    push_item(KIND_WRITE, 16'd0, 16'd0);
    push_item(KIND_WRITE, 16'd128, 16'd0);
    push_item(KIND_WRITE, 16'd128, 16'd1);
    push_item(KIND_WRITE, 16'd0, 16'd129);
    push_item(KIND_WRITE, 16'hFFFF, 16'hFFFF);
    push_item(KIND_WRITE, 16'd126, 16'd1);
  endtask

  // Rewrite passes silently when checking is off, stops the walk when on.
  task automatic test_rewrite_flag();
    push_item(KIND_WRITE, 16'd126, 16'd1);
    drain();
    write_register(CFG_REJECT_REWRITE, 16'd1);
    push_item(KIND_WRITE, 16'd126, 16'd1);
    push_item(KIND_WRITE, 16'd0, 16'd1);
    push_item(KIND_REPORT, 16'h0000, 16'h0000);
  endtask

  // Window that runs past the top of the address space; size clamped to the store.
  task automatic test_wrapped_window();
    drain();
    write_register(CFG_WINDOW_START, 16'hFFC0);
    write_register(CFG_WINDOW_WORDS, 16'd255);
    push_item(KIND_WRITE, 16'hFFBF, 16'd1);
    push_item(KIND_WRITE, 16'hFFFE, 16'd1);
    // Ends exactly at start + size beyond 16 bits: in range, first word already set
    push_item(KIND_WRITE, 16'hFFFE, 16'h0042);
    push_item(KIND_WRITE, 16'hFFFE, 16'h0043);
    // Third run starts past 0xFFFF and shows up wrapped
    push_item(KIND_REPORT, 16'hFFFF, 16'hFFFF);
  endtask

  // Zero-size window: no gaps, only a zero-length write at the start fits.
  task automatic test_empty_window();
    drain();
    write_register(CFG_WINDOW_WORDS, 16'd0);
    push_item(KIND_REPORT, 16'h0000, 16'h0000);
    push_item(KIND_WRITE, 16'hFFC0, 16'd0);
    push_item(KIND_WRITE, 16'hFFC0, 16'd1);
  endtask

  // Mark every even word in random order so a report yields the full 64 gaps.
  // Only single even words, zero-length writes and out-of-range noise go in, keeping odd words free.
  task automatic test_checkerboard_runs();
    logic [ADDR_W-1:0] base;
    int unsigned order[$];
    int unsigned j, pick, tmp, k;
    drain();
    base = 16'($urandom_range(0, 16'hFF80));
    write_register(CFG_WINDOW_START, base);
    write_register(CFG_WINDOW_WORDS, 16'd128);
    write_register(CFG_REJECT_REWRITE, 16'($urandom_range(0, 1)));
    for (k = 0; k < MAP_WORDS; k += 2)
      if (!word_written[k]) order.push_back(k);
    for (j = order.size() - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    foreach (order[i]) begin
      case ($urandom_range(0, 9))
        0: push_item(KIND_WRITE, base + 16'($urandom_range(0, 127)),
                     16'($urandom_range(129, 65535)));
        1: push_item(KIND_WRITE, base + 16'(2 * $urandom_range(0, 63)), 16'd0);
        default: ;
      endcase
      push_item(KIND_WRITE, base + 16'(order[i]), 16'd1);
    end
    // Repeat a few marked even words: ok or rewrite, never a new mark
    repeat (3) push_item(KIND_WRITE, base + 16'(2 * $urandom_range(0, 63)), 16'd1);
    push_item(KIND_REPORT, 16'($urandom), 16'($urandom));
  endtask

  // Random window settings, then mostly in-window writes with random content,
  // some reports and some full-range noise.
  task automatic test_mixed_traffic(input int unsigned count, input bit quiet);
    logic [ADDR_W-1:0]  base;
    logic [WORDS_W-1:0] words;
    int unsigned size, max_off, off, room, len, n, pick;
    drain();
    case ($urandom_range(0, 3))
      0:       base = 16'h0000;
      1:       base = 16'hFFFF - 16'($urandom_range(0, 130));
      default: base = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       words = 8'd0;
      1:       words = 8'd255;
      2:       words = 8'($urandom_range(129, 254));
      3:       words = 8'd128;
      default: words = 8'($urandom_range(1, 128));
    endcase
    write_register(CFG_WINDOW_START, base);
    write_register(CFG_WINDOW_WORDS, 16'(words));
    write_register(CFG_REJECT_REWRITE, 16'($urandom_range(0, 1)));
    calm = quiet;
    size = (words < MAP_WORDS) ? words : MAP_WORDS;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      priority if (pick < 14) begin
        if (size == 0) begin
          push_item(KIND_WRITE, base, 16'd0);
        end else begin
          max_off = size - 1;
          if (32'(base) + max_off > 32'hFFFF) max_off = 32'hFFFF - 32'(base);
          off  = $urandom_range(0, max_off);
          room = size - off;
          len  = ($urandom_range(0, 7) == 0) ? room
                                             : $urandom_range(0, (room < 6) ? room : 6);
          push_item(KIND_WRITE, base + 16'(off), 16'(len));
        end
      end else if (pick < 16) begin
        push_item(KIND_REPORT, 16'($urandom), 16'($urandom));
      end else begin
        push_item(KIND_WRITE, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_WINDOW_START;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_WRITE;
    in_ch.addr   = '0;
    in_ch.length = '0;
    out_ch.ready = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_fresh_window();
    test_range_edges();
    test_rewrite_flag();
    test_wrapped_window();
    test_empty_window();
    test_checkerboard_runs();
    test_mixed_traffic(20, 1'b0);
    test_mixed_traffic(20, 1'b0);
    test_mixed_traffic(20, 1'b0);
    // Last stretch runs with no idling on either side
    test_mixed_traffic(20, 1'b1);
    drain();

    $display("coverage: %0d items (%0d gap reports), %0d results checked, %0d mismatches",
             n_items, n_reports, n_results, mismatches);
    $display("coverage: %0d range rejects, %0d rewrite stops, up to %0d gaps in one report",
             n_range, n_rewrite, most_gaps);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
